// File: rtl/epoch_seconds_to_utc_calendar_unit_defines.svh
// assertion macros for the epoch seconds to utc calendar unit
// depends on nothing; users supply clk and arst_n in scope
`ifndef EPOCH_SECONDS_TO_UTC_CALENDAR_UNIT_DEFINES_SVH
`define EPOCH_SECONDS_TO_UTC_CALENDAR_UNIT_DEFINES_SVH
`ifndef SYNTH
`define ESUC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
`define ESUC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define ESUC_ASSERT(lbl, prop)
`define ESUC_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// File: rtl/esuc_pkg.sv
// constants for the epoch seconds to utc calendar unit
// depends on nothing
`default_nettype none
package esuc_pkg;
	localparam int SECONDS_BITS = 40;
	localparam int LATENCY = 15;
	// day count offset: shifts to 0000-03-01 plus 44 whole 400-year eras
	localparam longint DAY_OFFS = 64'd719468 + 64'd146097 * 64'd44;
	localparam longint SEC_OFFS = DAY_OFFS * 64'd86400;
	localparam int YEAR_BIAS = 44 * 400 + 1900;

	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		unique case (mp)
			4'd0: r = 9'd0;
			4'd1: r = 9'd31;
			4'd2: r = 9'd61;
			4'd3: r = 9'd92;
			4'd4: r = 9'd122;
			4'd5: r = 9'd153;
			4'd6: r = 9'd184;
			4'd7: r = 9'd214;
			4'd8: r = 9'd245;
			4'd9: r = 9'd275;
			4'd10: r = 9'd306;
			4'd11: r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// File: rtl/epoch_seconds_to_utc_calendar_unit.sv
// epoch seconds to utc calendar: fifteen stage pipeline
// from the start transfer to done, one item per cycle
// throughput; the deepest stage is one narrow constant multiply plus add
// busy stays low; the result is on the ports for one cycle with done high
// arst_n clears all valid bits; payload registers are not reset
// depends on esuc_pkg and epoch_seconds_to_utc_calendar_unit_defines.svh
`default_nettype none
`include "epoch_seconds_to_utc_calendar_unit_defines.svh"
module epoch_seconds_to_utc_calendar_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [esuc_pkg::SECONDS_BITS-1:0] epoch_seconds,
	output logic done,
	output logic [5:0] second_of_minute,
	output logic [5:0] minute_of_hour,
	output logic [4:0] hour_of_day,
	output logic [4:0] day_of_month,
	output logic [3:0] month_index,
	output logic signed [15:0] years_since_1900,
	output logic [2:0] weekday,
	output logic [8:0] day_of_year
);
	import esuc_pkg::*;

	// valid bit per stage, travels with the data
	logic [LATENCY:1] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-1:1], start};
		end
	end

	assign busy = 1'b0;
	assign done = vld_q[LATENCY];

	// s1: bias seconds so the value is never negative; bias is whole days
	logic [40:0] u_s1;
	always_ff @(posedge clk) begin
		u_s1 <= {epoch_seconds[SECONDS_BITS-1], epoch_seconds} + SEC_OFFS[40:0];
	end

	// 86400 = 128 * 675; divide u>>7 by 675 in two chunks of 17 bits
	// s2: estimate of high chunk quotient
	logic [24:0] p_vh;
	logic [7:0]  qh0_s2;
	logic [16:0] vh_s2, vl_s2;
	logic [6:0]  lo_s2;
	assign p_vh = u_s1[40:24] * 8'd194;
	always_ff @(posedge clk) begin
		qh0_s2 <= p_vh[24:17];
		vh_s2  <= u_s1[40:24];
		vl_s2  <= u_s1[23:7];
		lo_s2  <= u_s1[6:0];
	end

	// s3: correct the high chunk
	logic [16:0] rh0;
	logic [7:0]  qh_s3;
	logic [9:0]  rh_s3;
	logic [16:0] vl_s3;
	logic [6:0]  lo_s3;
	assign rh0 = vh_s2 - 17'(qh0_s2 * 10'd675);
	always_ff @(posedge clk) begin
		if (rh0 >= 17'd675) begin
			qh_s3 <= qh0_s2 + 8'd1;
			rh_s3 <= 10'(rh0 - 17'd675);
		end else begin
			qh_s3 <= qh0_s2;
			rh_s3 <= rh0[9:0];
		end
		vl_s3 <= vl_s2;
		lo_s3 <= lo_s2;
	end

	// s4: estimate of low chunk quotient, remainder of high chunk carried in
	logic [26:0] w_c;
	logic [44:0] p_w;
	logic [16:0] q20_s4;
	logic [26:0] w_s4;
	logic [7:0]  qh_s4;
	logic [6:0]  lo_s4;
	assign w_c = {rh_s3, vl_s3};
	assign p_w = w_c * 18'd198841;
	always_ff @(posedge clk) begin
		q20_s4 <= p_w[43:27];
		w_s4   <= w_c;
		qh_s4  <= qh_s3;
		lo_s4  <= lo_s3;
	end

	// s5: day number and second of day
	logic [26:0] rw0;
	logic [24:0] zz_s5;
	logic [16:0] rem_s5;
	assign rw0 = w_s4 - 27'(q20_s4 * 10'd675);
	always_ff @(posedge clk) begin
		if (rw0 >= 27'd675) begin
			zz_s5  <= {qh_s4, 17'(q20_s4 + 17'd1)};
			rem_s5 <= {10'(rw0 - 27'd675), lo_s4};
		end else begin
			zz_s5  <= {qh_s4, q20_s4};
			rem_s5 <= {rw0[9:0], lo_s4};
		end
	end

	// s6: estimates of era, weekday and hour
	logic [24:0] x7_c;
	logic [47:0] p_wd;
	logic [32:0] p_era;
	logic [22:0] p_hr;
	logic [22:0] wq0_s6;
	logic [7:0]  era0_s6;
	logic [4:0]  hr0_s6;
	logic [24:0] x7_s6, zz_s6;
	logic [16:0] rem_s6;
	assign x7_c  = zz_s5 + 25'd3;
	assign p_wd  = x7_c * 23'd4793490;
	assign p_era = zz_s5 * 8'd229;
	assign p_hr  = rem_s5 * 6'd36;
	always_ff @(posedge clk) begin
		wq0_s6  <= p_wd[47:25];
		era0_s6 <= p_era[32:25];
		hr0_s6  <= p_hr[21:17];
		x7_s6   <= x7_c;
		zz_s6   <= zz_s5;
		rem_s6  <= rem_s5;
	end

	// s7: corrections: weekday, era and day of era, hour and second of hour
	logic [24:0] wr0, de0;
	logic [16:0] rs0;
	logic [2:0]  wd_s7;
	logic [7:0]  era_s7;
	logic [17:0] doe_s7;
	logic [4:0]  hr_s7;
	logic [11:0] rs_s7;
	assign wr0 = x7_s6 - 25'(wq0_s6 * 3'd7);
	assign de0 = zz_s6 - 25'(era0_s6 * 18'd146097);
	assign rs0 = rem_s6 - 17'(hr0_s6 * 12'd3600);
	always_ff @(posedge clk) begin
		wd_s7 <= (wr0 >= 25'd7) ? 3'(wr0 - 25'd7) : wr0[2:0];
		if (de0 >= 25'd146097) begin
			era_s7 <= era0_s6 + 8'd1;
			doe_s7 <= 18'(de0 - 25'd146097);
		end else begin
			era_s7 <= era0_s6;
			doe_s7 <= de0[17:0];
		end
		if (rs0 >= 17'd3600) begin
			hr_s7 <= hr0_s6 + 5'd1;
			rs_s7 <= 12'(rs0 - 17'd3600);
		end else begin
			hr_s7 <= hr0_s6;
			rs_s7 <= rs0[11:0];
		end
	end

	// s8: estimates for the 4/100/400 year terms and the minute
	logic [25:0] p_a;
	logic [20:0] p_b;
	logic [18:0] p_m;
	logic [7:0]  a0_s8;
	logic [2:0]  b0_s8;
	logic        c_s8;
	logic [5:0]  mn0_s8;
	logic [17:0] doe_s8;
	logic [11:0] rs_s8;
	logic [7:0]  era_s8;
	logic [2:0]  wd_s8;
	logic [4:0]  hr_s8;
	assign p_a = doe_s7 * 8'd179;
	assign p_b = doe_s7 * 3'd7;
	assign p_m = rs_s7 * 7'd68;
	always_ff @(posedge clk) begin
		a0_s8  <= p_a[25:18];
		b0_s8  <= p_b[20:18];
		c_s8   <= (doe_s7 == 18'd146096);
		mn0_s8 <= p_m[17:12];
		doe_s8 <= doe_s7;
		rs_s8  <= rs_s7;
		era_s8 <= era_s7;
		wd_s8  <= wd_s7;
		hr_s8  <= hr_s7;
	end

	// s9: corrections of those terms, minute and second
	logic [17:0] ra0, rb0;
	logic [11:0] rm0;
	logic [7:0]  a_s9;
	logic [2:0]  b_s9;
	logic        c_s9;
	logic [5:0]  mn_s9, sc_s9;
	logic [17:0] doe_s9;
	logic [7:0]  era_s9;
	logic [2:0]  wd_s9;
	logic [4:0]  hr_s9;
	assign ra0 = doe_s8 - 18'(a0_s8 * 11'd1460);
	assign rb0 = doe_s8 - 18'(b0_s8 * 16'd36524);
	assign rm0 = rs_s8 - 12'(mn0_s8 * 6'd60);
	always_ff @(posedge clk) begin
		a_s9 <= (ra0 >= 18'd1460) ? a0_s8 + 8'd1 : a0_s8;
		b_s9 <= (rb0 >= 18'd36524) ? b0_s8 + 3'd1 : b0_s8;
		c_s9 <= c_s8;
		if (rm0 >= 12'd60) begin
			mn_s9 <= mn0_s8 + 6'd1;
			sc_s9 <= 6'(rm0 - 12'd60);
		end else begin
			mn_s9 <= mn0_s8;
			sc_s9 <= rm0[5:0];
		end
		doe_s9 <= doe_s8;
		era_s9 <= era_s8;
		wd_s9  <= wd_s8;
		hr_s9  <= hr_s8;
	end

	// s10: day of era folded to a 365-day year count
	logic [17:0] t_s10, doe_s10;
	logic [7:0]  era_s10;
	logic [2:0]  wd_s10;
	logic [4:0]  hr_s10;
	logic [5:0]  mn_s10, sc_s10;
	always_ff @(posedge clk) begin
		t_s10   <= doe_s9 - 18'(a_s9) + 18'(b_s9) - 18'(c_s9);
		doe_s10 <= doe_s9;
		era_s10 <= era_s9;
		wd_s10  <= wd_s9;
		hr_s10  <= hr_s9;
		mn_s10  <= mn_s9;
		sc_s10  <= sc_s9;
	end

	// s11: year of era estimate
	logic [27:0] p_y;
	logic [8:0]  yoe0_s11;
	logic [17:0] t_s11, doe_s11;
	logic [7:0]  era_s11;
	logic [2:0]  wd_s11;
	logic [4:0]  hr_s11;
	logic [5:0]  mn_s11, sc_s11;
	assign p_y = t_s10 * 10'd718;
	always_ff @(posedge clk) begin
		yoe0_s11 <= p_y[26:18];
		t_s11    <= t_s10;
		doe_s11  <= doe_s10;
		era_s11  <= era_s10;
		wd_s11   <= wd_s10;
		hr_s11   <= hr_s10;
		mn_s11   <= mn_s10;
		sc_s11   <= sc_s10;
	end

	// s12: year of era correction
	logic [17:0] ry0;
	logic [8:0]  yoe_s12;
	logic [17:0] doe_s12;
	logic [7:0]  era_s12;
	logic [2:0]  wd_s12;
	logic [4:0]  hr_s12;
	logic [5:0]  mn_s12, sc_s12;
	assign ry0 = t_s11 - 18'(yoe0_s11 * 9'd365);
	always_ff @(posedge clk) begin
		yoe_s12 <= (ry0 >= 18'd365) ? yoe0_s11 + 9'd1 : yoe0_s11;
		doe_s12 <= doe_s11;
		era_s12 <= era_s11;
		wd_s12  <= wd_s11;
		hr_s12  <= hr_s11;
		mn_s12  <= mn_s11;
		sc_s12  <= sc_s11;
	end

	// s13: day of the march-based year
	logic [1:0]  hund;
	logic [17:0] doy_c;
	logic [8:0]  doy_s13, yoe_s13;
	logic [7:0]  era_s13;
	logic [2:0]  wd_s13;
	logic [4:0]  hr_s13;
	logic [5:0]  mn_s13, sc_s13;
	always_comb begin
		priority if (yoe_s12 >= 9'd300) hund = 2'd3;
		else if (yoe_s12 >= 9'd200) hund = 2'd2;
		else if (yoe_s12 >= 9'd100) hund = 2'd1;
		else hund = 2'd0;
	end
	assign doy_c = doe_s12 - 18'(yoe_s12 * 9'd365) - 18'(yoe_s12[8:2]) + 18'(hund);
	always_ff @(posedge clk) begin
		doy_s13 <= doy_c[8:0];
		yoe_s13 <= yoe_s12;
		era_s13 <= era_s12;
		wd_s13  <= wd_s12;
		hr_s13  <= hr_s12;
		mn_s13  <= mn_s12;
		sc_s13  <= sc_s12;
	end

	// s14: march-based month by comparing against month starts
	logic [3:0] mp_c;
	logic [3:0] mp_s14;
	logic [8:0] doy_s14, yoe_s14;
	logic [7:0] era_s14;
	logic [2:0] wd_s14;
	logic [4:0] hr_s14;
	logic [5:0] mn_s14, sc_s14;
	always_comb begin
		mp_c = 4'd0;
		for (int k = 1; k < 12; k++) begin
			mp_c = mp_c + 4'(doy_s13 >= month_start(4'(k)));
		end
	end
	always_ff @(posedge clk) begin
		mp_s14  <= mp_c;
		doy_s14 <= doy_s13;
		yoe_s14 <= yoe_s13;
		era_s14 <= era_s13;
		wd_s14  <= wd_s13;
		hr_s14  <= hr_s13;
		mn_s14  <= mn_s13;
		sc_s14  <= sc_s13;
	end

	// s15: final fields; jan and feb belong to the next calendar year
	logic        jf;
	logic [8:0]  y400;
	logic        leap;
	logic [31:0] yr_c;
	logic [8:0]  yday_c;
	assign jf     = (mp_s14 >= 4'd10);
	assign y400   = yoe_s14 + 9'(jf);
	assign leap   = (y400[1:0] == 2'd0) &&
		!((y400 == 9'd100) || (y400 == 9'd200) || (y400 == 9'd300));
	assign yr_c   = 32'(y400) + 32'(era_s14) * 32'd400 - 32'(YEAR_BIAS);
	assign yday_c = jf ? 9'(doy_s14 - 9'd306) : 9'(doy_s14 + 9'd59 + 9'(leap));
	always_ff @(posedge clk) begin
		second_of_minute <= sc_s14;
		minute_of_hour   <= mn_s14;
		hour_of_day      <= hr_s14;
		day_of_month     <= 5'(doy_s14 - month_start(mp_s14) + 9'd1);
		month_index      <= jf ? 4'(mp_s14 - 4'd10) : 4'(mp_s14 + 4'd2);
		years_since_1900 <= yr_c[15:0];
		weekday          <= wd_s14;
		day_of_year      <= yday_c;
	end

	// checks
	`ESUC_ASSERT_IMPL(a_latency, start, ##15 done)
	`ESUC_ASSERT_IMPL(a_time_rng, done,
		(second_of_minute < 6'd60) && (minute_of_hour < 6'd60) && (hour_of_day < 5'd24))
	`ESUC_ASSERT_IMPL(a_date_rng, done,
		(day_of_month != 5'd0) && (month_index < 4'd12) && (weekday < 3'd7))
	`ESUC_ASSERT_IMPL(a_jan_yday, done && (month_index == 4'd0),
		day_of_year == 9'(day_of_month - 5'd1))
	`ESUC_ASSERT(a_no_busy, !busy)
endmodule
`default_nettype wire
